// ===== design/afir_pkg.sv =====
package afir_pkg;

   localparam int MAX_FRAMES = 256;
   localparam int FRAME_AW   = $clog2(MAX_FRAMES);
   localparam int CNT_W      = FRAME_AW + 1;
   localparam int CENTI_W    = 16;
   localparam int DELAY_W    = 20;
   localparam int TOTAL_W    = 28;
   localparam int TIME_W     = 48;
   localparam int MOD_CNT_W  = $clog2(TIME_W);

   localparam logic [DELAY_W-1:0] DEFAULT_DELAY_MS = DELAY_W'(100);
   localparam logic [DELAY_W-1:0] MIN_DELAY_MS     = DELAY_W'(20);
   localparam logic [DELAY_W-1:0] MS_PER_CENTI     = DELAY_W'(10);

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic REG_LOOP   = 1'b0;
   localparam logic REG_FRAMES = 1'b1;

   typedef struct packed {
      logic wr_delay;
      logic latch_query;
      logic scan_sum;
      logic scan_walk;
      logic mod_start;
      logic hold_last;
      logic res_zero;
      logic load_out;
   } afir_cmd_type;

   typedef struct packed {
      logic multi;
      logic dirty;
      logic loop;
      logic t_ge_total;
      logic scan_done;
      logic mod_done;
   } afir_sts_type;

endpackage

// ===== design/animated_frame_index_resolver.sv =====
// Channel  Direction  Beat
// req_     in         kind, frame_slot, delay_centis, elapsed_ms (valid/ready)
// rsp_     out        frame_index, animated, one beat per query (valid/ready)
// csr_     in         APB-style register port: loop_enable, frame_count
//
// A delay write is taken in the idle state. A query with fewer than two frames in use
// returns frame 0; else the delay total is summed (only after reset, a delay write or
// a frame_count change), the remainder is taken in loop mode, and the delay store is
// walked, one entry a cycle through its registered read port; a non-loop query past
// the total returns the last frame in use without a walk.
// Reset is synchronous; the delay store reads 100 ms per entry until written.
// A finished result waits in the output register while the next beat is taken.
module animated_frame_index_resolver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_frame_slot,
   input  logic [15:0] req_delay_centis,
   input  logic [47:0] req_elapsed_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_frame_index,
   output logic        rsp_animated,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import afir_pkg::*;

   logic             loop_ff;
   logic [CNT_W-1:0] frames_ff;
   logic             csr_wr;
   logic             frames_wr;
   afir_cmd_type     cmd;
   afir_sts_type     sts;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign frames_wr  = csr_wr && (csr_paddr[2] == REG_FRAMES);

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_ff   <= 1'b1;
         frames_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_LOOP:   loop_ff   <= csr_pwdata[0];
            REG_FRAMES: frames_ff <= csr_pwdata[CNT_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_LOOP:   csr_prdata = {31'b0, loop_ff};
         REG_FRAMES: csr_prdata = {{(32-CNT_W){1'b0}}, frames_ff};
         default:    csr_prdata = '0;
      endcase
   end

   afir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   afir_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_frame_slot   (req_frame_slot),
      .req_delay_centis (req_delay_centis),
      .req_elapsed_ms   (req_elapsed_ms),
      .loop_enable      (loop_ff),
      .frame_count      (frames_ff),
      .frame_count_wr   (frames_wr),
      .rsp_frame_index  (rsp_frame_index),
      .rsp_animated     (rsp_animated)
   );

endmodule

// ===== design/afir_ctrl.sv =====
module afir_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_kind,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output afir_pkg::afir_cmd_type cmd,
   input  afir_pkg::afir_sts_type sts
);
   import afir_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SUM,
      ST_CHECK,
      ST_MOD,
      ST_WALK,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_QUERY) begin
                  cmd.latch_query = 1'b1;
                  state_in        = ST_START;
               end else begin
                  cmd.wr_delay = 1'b1;
               end
            end
         end
         ST_START: begin
            if (!sts.multi) begin
               cmd.res_zero = 1'b1;
               state_in     = ST_DONE;
            end else if (sts.dirty) begin
               cmd.scan_sum = 1'b1;
               state_in     = ST_SUM;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_SUM: begin
            if (sts.scan_done) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.loop) begin
               cmd.mod_start = 1'b1;
               state_in      = ST_MOD;
            end else if (sts.t_ge_total) begin
               cmd.hold_last = 1'b1;
               state_in      = ST_DONE;
            end else begin
               cmd.scan_walk = 1'b1;
               state_in      = ST_WALK;
            end
         end
         ST_MOD: begin
            if (sts.mod_done) begin
               cmd.scan_walk = 1'b1;
               state_in      = ST_WALK;
            end
         end
         ST_WALK: begin
            if (sts.scan_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_out | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/afir_dp.sv =====
module afir_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  afir_pkg::afir_cmd_type                 cmd,
   output afir_pkg::afir_sts_type                 sts,
   input  logic [afir_pkg::FRAME_AW-1:0]          req_frame_slot,
   input  logic [afir_pkg::CENTI_W-1:0]           req_delay_centis,
   input  logic [afir_pkg::TIME_W-1:0]            req_elapsed_ms,
   input  logic                                   loop_enable,
   input  logic [afir_pkg::CNT_W-1:0]             frame_count,
   input  logic                                   frame_count_wr,
   output logic [afir_pkg::FRAME_AW-1:0]          rsp_frame_index,
   output logic                                   rsp_animated
);
   import afir_pkg::*;

   // delay store; an entry never written reads as the default delay
   logic [DELAY_W-1:0]    delay_mem [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] valid_ff;

   logic [CNT_W-1:0]    used_n;
   logic [FRAME_AW-1:0] last_idx;
   logic [DELAY_W-1:0]  ms_raw, ms_store;

   logic [TIME_W-1:0]   t_ff, t_in;
   logic [TOTAL_W-1:0]  total_ff;
   logic                dirty_ff, dirty_in;

   logic                scan_on_ff, scan_on_in;
   logic                walk_mode_ff;
   logic [FRAME_AW-1:0] iss_ff;
   logic                rd_live_ff, rd_live_in;
   logic [FRAME_AW-1:0] rd_idx_ff;
   logic [DELAY_W-1:0]  rd_data_ff;
   logic                rd_vld_ff;
   logic [TOTAL_W-1:0]  acc_ff, acc_sum;
   logic [DELAY_W-1:0]  entry;
   logic [TOTAL_W-1:0]  target;
   logic                finish;
   logic                scan_done_ff;

   logic                mod_on_ff;
   logic [MOD_CNT_W-1:0] mod_cnt_ff;
   logic                mod_done_ff;
   logic [TOTAL_W-1:0]  rem_ff, rem_in;
   logic [TOTAL_W:0]    shifted, diff;

   logic [FRAME_AW-1:0] res_idx_ff;
   logic [FRAME_AW-1:0] out_idx_ff;
   logic                out_anim_ff;

   assign used_n   = (frame_count > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : frame_count;
   assign last_idx = FRAME_AW'(used_n - CNT_W'(1));

   assign ms_raw   = DELAY_W'(req_delay_centis) * MS_PER_CENTI;
   assign ms_store = (ms_raw < MIN_DELAY_MS) ? MIN_DELAY_MS : ms_raw;

   always_ff @(posedge clock) begin
      if (cmd.wr_delay) delay_mem[req_frame_slot] <= ms_store;
      if (scan_on_ff) begin
         rd_data_ff <= delay_mem[iss_ff];
         rd_vld_ff  <= valid_ff[iss_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.wr_delay) begin
         valid_ff[req_frame_slot] <= 1'b1;
      end
   end

   // scan: read one entry a cycle, accumulate in the cycle after the read
   assign entry   = rd_vld_ff ? rd_data_ff : DEFAULT_DELAY_MS;
   assign acc_sum = acc_ff + TOTAL_W'(entry);
   assign target  = loop_enable ? rem_ff : t_ff[TOTAL_W-1:0];
   assign finish  = rd_live_ff &&
                    ((rd_idx_ff == last_idx) || (walk_mode_ff && (target < acc_sum)));

   assign scan_on_in = scan_on_ff && (iss_ff != last_idx) && !finish;
   assign rd_live_in = scan_on_ff && !finish;
   assign dirty_in   = (cmd.wr_delay || frame_count_wr) ? 1'b1 :
                       ((finish && !walk_mode_ff) ? 1'b0 : dirty_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_on_ff   <= 1'b0;
         rd_live_ff   <= 1'b0;
         scan_done_ff <= 1'b0;
         dirty_ff     <= 1'b1;
      end else begin
         dirty_ff     <= dirty_in;
         scan_done_ff <= finish;
         if (cmd.scan_sum || cmd.scan_walk) begin
            scan_on_ff <= 1'b1;
            rd_live_ff <= 1'b0;
         end else begin
            scan_on_ff <= scan_on_in;
            rd_live_ff <= rd_live_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_sum || cmd.scan_walk) begin
         walk_mode_ff <= cmd.scan_walk;
         iss_ff       <= '0;
         acc_ff       <= '0;
      end else begin
         if (scan_on_ff) iss_ff <= iss_ff + FRAME_AW'(1);
         if (rd_live_ff) acc_ff <= acc_sum;
      end
      rd_idx_ff <= iss_ff;
      if (finish && !walk_mode_ff) total_ff <= acc_sum;
      if (finish && walk_mode_ff) res_idx_ff <= rd_idx_ff;
      else if (cmd.hold_last)     res_idx_ff <= last_idx;
      else if (cmd.res_zero)      res_idx_ff <= '0;
   end

   // restoring remainder, one bit of elapsed time a cycle
   assign shifted = {rem_ff, t_ff[TIME_W-1]};
   assign diff    = shifted - {1'b0, total_ff};
   assign rem_in  = (shifted >= {1'b0, total_ff}) ? diff[TOTAL_W-1:0] : shifted[TOTAL_W-1:0];
   assign t_in    = cmd.latch_query ? req_elapsed_ms :
                    (mod_on_ff ? {t_ff[TIME_W-2:0], 1'b0} : t_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_on_ff   <= 1'b0;
         mod_done_ff <= 1'b0;
      end else begin
         mod_done_ff <= mod_on_ff && (mod_cnt_ff == '0);
         if (cmd.mod_start)             mod_on_ff <= 1'b1;
         else if (mod_cnt_ff == '0)     mod_on_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in;
      if (cmd.mod_start) begin
         rem_ff     <= '0;
         mod_cnt_ff <= MOD_CNT_W'(TIME_W - 1);
      end else if (mod_on_ff) begin
         rem_ff     <= rem_in;
         mod_cnt_ff <= mod_cnt_ff - MOD_CNT_W'(1);
      end
      if (cmd.load_out) begin
         out_idx_ff  <= res_idx_ff;
         out_anim_ff <= sts.multi;
      end
   end

   assign sts.multi      = (used_n > CNT_W'(1));
   assign sts.dirty      = dirty_ff;
   assign sts.loop       = loop_enable;
   assign sts.t_ge_total = (t_ff >= TIME_W'(total_ff));
   assign sts.scan_done  = scan_done_ff;
   assign sts.mod_done   = mod_done_ff;

   assign rsp_frame_index = out_idx_ff;
   assign rsp_animated    = out_anim_ff;

endmodule
